@@ hdl/expected_improvement_unit_top_macros.svh @@
`ifndef EXPECTED_IMPROVEMENT_UNIT_TOP_MACROS_SVH
`define EXPECTED_IMPROVEMENT_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define EIU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define EIU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/eiu_pkg.sv @@
package eiu_pkg;

  // Fraction bits of z
  localparam int EIU_FRAC_BITS = 16;

  // Table geometry, steps of 0.1 in z
  localparam int TAB_N = 76;
  localparam int TAB_W = $clog2(TAB_N);

  // Probability scale: units of 1e-9
  localparam logic [29:0] UNIT_E9   = 30'd1000000000;
  localparam logic [63:0] HALF_E9   = 64'd500000000;
  localparam logic [63:0] SAT_LIM   = 64'd2147483648000000000;

  // Divide by 1e9: floor(2^62 / 1e9) = 2^32 + RECIP_LO
  localparam logic [31:0] RECIP_LO  = 32'h12E0BE82;
  localparam logic [31:0] E9_X1     = 32'd1000000000;
  localparam logic [31:0] E9_X2     = 32'd2000000000;
  localparam logic [31:0] E9_X3     = 32'd3000000000;

  // Standard normal distribution at k*0.1
  localparam logic [29:0] CDF_TAB [TAB_N] = '{
    30'd500000000, 30'd539827837, 30'd579259709, 30'd617911422, 30'd655421742,
    30'd691462461, 30'd725746882, 30'd758036348, 30'd788144601, 30'd815939875,
    30'd841344746, 30'd864333939, 30'd884930330, 30'd903199515, 30'd919243341,
    30'd933192799, 30'd945200708, 30'd955434537, 30'd964069681, 30'd971283440,
    30'd977249868, 30'd982135579, 30'd986096552, 30'd989275890, 30'd991802464,
    30'd993790335, 30'd995338812, 30'd996533026, 30'd997444870, 30'd998134187,
    30'd998650102, 30'd999032397, 30'd999312862, 30'd999516576, 30'd999663071,
    30'd999767371, 30'd999840891, 30'd999892200, 30'd999927652, 30'd999951904,
    30'd999968329, 30'd999979342, 30'd999986654, 30'd999991460, 30'd999994587,
    30'd999996602, 30'd999997888, 30'd999998699, 30'd999999207, 30'd999999521,
    30'd999999713, 30'd999999830, 30'd999999900, 30'd999999942, 30'd999999967,
    30'd999999981, 30'd999999989, 30'd999999994, 30'd999999997, 30'd999999998,
    30'd999999999, 30'd999999999, 30'd1000000000, 30'd1000000000, 30'd1000000000,
    30'd1000000000, 30'd1000000000, 30'd1000000000, 30'd1000000000, 30'd1000000000,
    30'd1000000000, 30'd1000000000, 30'd1000000000, 30'd1000000000, 30'd1000000000,
    30'd1000000000
  };

  // Standard normal density at k*0.1
  localparam logic [28:0] PDF_TAB [TAB_N] = '{
    29'd398942280, 29'd396952547, 29'd391042694, 29'd381387815, 29'd368270140,
    29'd352065327, 29'd333224603, 29'd312253933, 29'd289691553, 29'd266085250,
    29'd241970725, 29'd217852177, 29'd194186055, 29'd171368592, 29'd149727466,
    29'd129517596, 29'd110920835, 29'd94049077, 29'd78950158, 29'd65615815,
    29'd53990967, 29'd43983596, 29'd35474593, 29'd28327038, 29'd22394530,
    29'd17528300, 29'd13582969, 29'd10420935, 29'd7915452, 29'd5952532,
    29'd4431848, 29'd3266819, 29'd2384088, 29'd1722569, 29'd1232219,
    29'd872683, 29'd611902, 29'd424780, 29'd291947, 29'd198656,
    29'd133830, 29'd89262, 29'd58943, 29'd38535, 29'd24942,
    29'd15984, 29'd10141, 29'd6370, 29'd3961, 29'd2439,
    29'd1487, 29'd897, 29'd536, 29'd317, 29'd186,
    29'd108, 29'd62, 29'd35, 29'd20, 29'd11,
    29'd6, 29'd3, 29'd2, 29'd1, 29'd1,
    29'd0, 29'd0, 29'd0, 29'd0, 29'd0,
    29'd0, 29'd0, 29'd0, 29'd0, 29'd0,
    29'd0
  };

endpackage

@@ hdl/eiu_if.sv @@
// Candidate beat: predicted mean and deviation
interface eiu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] predicted_mean;
  logic signed [31:0] std_dev;
  modport source (output valid, output predicted_mean, output std_dev, input ready);
  modport sink (input valid, input predicted_mean, input std_dev, output ready);
endinterface

// Result beat
interface eiu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] improvement;
  modport source (output valid, output improvement, input ready);
  modport sink (input valid, input improvement, output ready);
endinterface

// Best-value register write
interface eiu_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] best_value;
  modport source (output valid, output best_value, input ready);
  modport sink (input valid, input best_value, output ready);
endinterface

@@ hdl/expected_improvement_unit_top.sv @@
// Channel  Dir  Beat contents
// -------  ---  -----------------------------------------
// in_i     in   predicted_mean, std_dev (signed Q16.16)
// cfg_i    in   best_value (signed Q16.16), always ready
// out_o    out  improvement (signed Q16.16, saturated)
//
// One beat enters per cycle while out_o is not stalled; a result passes through
// FRAC_BITS + 13 register stages after its input beat is accepted: the
// bit-per-stage z divider plus table, interpolation, product, sum,
// reciprocal quotient, remainder and output stages.
// Reset clears the valid bits and best_value; payload registers are not reset.
// Each stage holds while the stage after it is full and blocked, so a stall
// on out_o backs up stage by stage and bubbles are squeezed out.
module expected_improvement_unit_top #(
  parameter int FRAC_BITS = eiu_pkg::EIU_FRAC_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  eiu_in_if.sink    in_i,
  eiu_cfg_if.sink   cfg_i,
  eiu_out_if.source out_o
);
  import eiu_pkg::*;

  `include "expected_improvement_unit_top_macros.svh"

  localparam int QB    = FRAC_BITS + 4;      // quotient bits of z
  localparam int RW    = FRAC_BITS + 35;     // divider remainder width
  localparam int ST_T  = QB + 1;             // table lookup
  localparam int ST_M  = QB + 2;             // interpolation products
  localparam int ST_C  = QB + 3;             // Phi / phi
  localparam int ST_P  = QB + 4;             // EI products
  localparam int ST_L0 = QB + 5;             // sum with offset
  localparam int ST_L1 = QB + 6;             // quotient estimate
  localparam int ST_L2 = QB + 7;             // remainder
  localparam int ST_O  = QB + 8;             // output register
  localparam int LAST  = ST_O;

  localparam logic [QB-1:0] Z_CAP  = QB'(8) << FRAC_BITS;
  localparam logic [QB-1:0] Z_LIM7 = QB'(7) << FRAC_BITS;
  localparam logic [QB-1:0] Z_L75  = QB'(15) << (FRAC_BITS - 1);
  localparam logic [TAB_W-1:0] IDX_MAX = TAB_W'(TAB_N - 2);

  typedef struct packed {
    logic [RW-1:0]      rem;
    logic [QB-1:0]      q;
    logic [30:0]        sd;
    logic signed [32:0] d;
    logic               neg;
    logic               zer;
    logic               ovf;
  } dv_t;

  typedef struct packed {
    logic [29:0]          ca;
    logic [29:0]          cb;
    logic [28:0]          pa;
    logic [28:0]          pb;
    logic [FRAC_BITS-1:0] f;
    logic                 gt7;
    logic                 ge75;
    logic [30:0]          sd;
    logic signed [32:0]   d;
    logic                 neg;
    logic                 zer;
  } tb_t;

  typedef struct packed {
    logic [29:0]        ca;
    logic [29:0]        cdel;
    logic               cup;
    logic [28:0]        pa;
    logic [28:0]        pdel;
    logic               pup;
    logic               gt7;
    logic               ge75;
    logic [30:0]        sd;
    logic signed [32:0] d;
    logic               neg;
    logic               zer;
  } ip_t;

  typedef struct packed {
    logic [29:0]        cdf;
    logic [28:0]        pdf;
    logic [30:0]        sd;
    logic signed [32:0] d;
    logic               zer;
  } pr_t;

  typedef struct packed {
    logic signed [63:0] pd;
    logic signed [63:0] ps;
    logic               zer;
  } pp_t;

  typedef struct packed {
    logic [61:0] y;
    logic        hi;
    logic        lo;
    logic        zer;
  } sm_t;

  typedef struct packed {
    logic [31:0] ylo;
    logic [31:0] qe;
    logic        hi;
    logic        lo;
    logic        zer;
  } qe_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] qe;
    logic        hi;
    logic        lo;
    logic        zer;
  } rm_t;

  logic signed [31:0] best_q;
  logic [LAST:0]      vld_q;
  logic [LAST:0]      en;

  dv_t dv_q [QB+1];
  dv_t dv_d [QB+1];
  tb_t t_q, t_d;
  ip_t m_q, m_d;
  pr_t c_q, c_d;
  pp_t p_q, p_d;
  sm_t s_q, s_d;
  qe_t e_q, e_d;
  rm_t r_q, r_d;
  logic signed [31:0] res_q, res_d;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (cfg_i.valid) begin
      best_q <= cfg_i.best_value;
    end
  end

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[LAST] = !vld_q[LAST] || out_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end
  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[LAST];
  assign out_o.improvement = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: difference, magnitude, divider setup, overflow of z
  always_comb begin
    logic [32:0]   dm;
    logic [RW-1:0] cmp;
    dv_d[0].d   = 33'(best_q) - 33'(in_i.predicted_mean);
    dv_d[0].neg = dv_d[0].d[32];
    dm          = dv_d[0].neg ? 33'(-dv_d[0].d) : 33'(dv_d[0].d);
    dv_d[0].zer = (in_i.std_dev <= 32'sd0);
    dv_d[0].sd  = in_i.std_dev[30:0];
    dv_d[0].ovf = {2'b00, dm} >= {in_i.std_dev[30:0], 4'b0000};
    dv_d[0].rem = RW'(dm) << FRAC_BITS;
    dv_d[0].q   = '0;
    // Restoring divider for |z|, one quotient bit per stage
    for (int j = 0; j < QB; j++) begin
      dv_d[j+1] = dv_q[j];
      cmp = RW'(dv_q[j].sd) << (QB - 1 - j);
      if (dv_q[j].rem >= cmp) begin
        dv_d[j+1].rem = dv_q[j].rem - cmp;
        dv_d[j+1].q[QB-1-j] = 1'b1;
      end
    end
  end

  // Table stage: clamp z, split 10*|z| into index and fraction
  always_comb begin
    logic [QB-1:0]    zm;
    logic [QB+3:0]    ten;
    logic [TAB_W-1:0] idx;
    zm = (dv_q[QB].ovf || dv_q[QB].q > Z_CAP) ? Z_CAP : dv_q[QB].q;
    ten = ({4'b0000, zm} << 3) + ({4'b0000, zm} << 1);
    idx = ten[FRAC_BITS+TAB_W-1:FRAC_BITS];
    if (idx > IDX_MAX) begin
      idx = IDX_MAX;
    end
    t_d.ca   = CDF_TAB[idx];
    t_d.cb   = CDF_TAB[idx + TAB_W'(1)];
    t_d.pa   = PDF_TAB[idx];
    t_d.pb   = PDF_TAB[idx + TAB_W'(1)];
    t_d.f    = ten[FRAC_BITS-1:0];
    t_d.gt7  = zm > Z_LIM7;
    t_d.ge75 = zm >= Z_L75;
    t_d.sd   = dv_q[QB].sd;
    t_d.d    = dv_q[QB].d;
    t_d.neg  = dv_q[QB].neg;
    t_d.zer  = dv_q[QB].zer;
  end

  // Interpolation step sizes
  always_comb begin
    logic [29:0]           cdiff;
    logic [28:0]           pdiff;
    logic [FRAC_BITS+29:0] cprod;
    logic [FRAC_BITS+28:0] pprod;
    m_d.cup = t_q.cb >= t_q.ca;
    m_d.pup = t_q.pb >= t_q.pa;
    cdiff   = m_d.cup ? (t_q.cb - t_q.ca) : (t_q.ca - t_q.cb);
    pdiff   = m_d.pup ? (t_q.pb - t_q.pa) : (t_q.pa - t_q.pb);
    cprod   = (FRAC_BITS+30)'(cdiff) * (FRAC_BITS+30)'(t_q.f);
    pprod   = (FRAC_BITS+29)'(pdiff) * (FRAC_BITS+29)'(t_q.f);
    m_d.cdel = cprod[FRAC_BITS+29:FRAC_BITS];
    m_d.pdel = pprod[FRAC_BITS+28:FRAC_BITS];
    m_d.ca   = t_q.ca;
    m_d.pa   = t_q.pa;
    m_d.gt7  = t_q.gt7;
    m_d.ge75 = t_q.ge75;
    m_d.sd   = t_q.sd;
    m_d.d    = t_q.d;
    m_d.neg  = t_q.neg;
    m_d.zer  = t_q.zer;
  end

  // Phi with mirror and tails, phi with cutoff
  always_comb begin
    logic [29:0] ci;
    ci = m_q.cup ? (m_q.ca + m_q.cdel) : (m_q.ca - m_q.cdel);
    if (m_q.gt7) begin
      c_d.cdf = m_q.neg ? '0 : UNIT_E9;
    end else begin
      c_d.cdf = m_q.neg ? (UNIT_E9 - ci) : ci;
    end
    if (m_q.ge75) begin
      c_d.pdf = '0;
    end else begin
      c_d.pdf = m_q.pup ? (m_q.pa + m_q.pdel) : (m_q.pa - m_q.pdel);
    end
    c_d.sd  = m_q.sd;
    c_d.d   = m_q.d;
    c_d.zer = m_q.zer;
  end

  // EI products, one multiplier each
  always_comb begin
    p_d.pd  = 64'(c_q.d) * $signed({34'd0, c_q.cdf});
    p_d.ps  = $signed({33'd0, c_q.sd}) * $signed({35'd0, c_q.pdf});
    p_d.zer = c_q.zer;
  end

  // Sum with rounding, saturation flags, offset to a nonnegative dividend
  always_comb begin
    logic signed [63:0] x;
    logic [63:0]        y;
    x = p_q.pd + p_q.ps + $signed(HALF_E9);
    y = x + SAT_LIM;
    s_d.hi  = x >= $signed(SAT_LIM);
    s_d.lo  = x < -$signed(SAT_LIM);
    s_d.y   = y[61:0];
    s_d.zer = p_q.zer;
  end

  // Quotient estimate from the top 32 dividend bits, at most three low
  always_comb begin
    logic [31:0] yh;
    logic [63:0] prod;
    yh       = s_q.y[61:30];
    prod     = 64'(yh) * 64'(RECIP_LO);
    e_d.qe   = yh + prod[63:32];
    e_d.ylo  = s_q.y[31:0];
    e_d.hi   = s_q.hi;
    e_d.lo   = s_q.lo;
    e_d.zer  = s_q.zer;
  end

  // Remainder of the estimate, below 4e9 so 32 bits hold it
  always_comb begin
    logic [31:0] lp;
    lp      = e_q.qe * E9_X1;
    r_d.r   = e_q.ylo - lp;
    r_d.qe  = e_q.qe;
    r_d.hi  = e_q.hi;
    r_d.lo  = e_q.lo;
    r_d.zer = e_q.zer;
  end

  // Correct quotient, remove offset, saturate, zero for nonpositive deviation
  always_comb begin
    logic [1:0]  corr;
    logic [31:0] q;
    corr = {1'b0, r_q.r >= E9_X1} + {1'b0, r_q.r >= E9_X2} + {1'b0, r_q.r >= E9_X3};
    q    = r_q.qe + {30'd0, corr};
    if (r_q.zer) begin
      res_d = '0;
    end else if (r_q.hi) begin
      res_d = 32'sh7FFFFFFF;
    end else if (r_q.lo) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = $signed({~q[31], q[30:0]});
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= QB; j++) begin
      if (en[j]) begin
        dv_q[j] <= dv_d[j];
      end
    end
    if (en[ST_T]) begin
      t_q <= t_d;
    end
    if (en[ST_M]) begin
      m_q <= m_d;
    end
    if (en[ST_C]) begin
      c_q <= c_d;
    end
    if (en[ST_P]) begin
      p_q <= p_d;
    end
    if (en[ST_L0]) begin
      s_q <= s_d;
    end
    if (en[ST_L1]) begin
      e_q <= e_d;
    end
    if (en[ST_L2]) begin
      r_q <= r_d;
    end
    if (en[ST_O]) begin
      res_q <= res_d;
    end
  end

  // Checks
  `EIU_ASSERT_NEXT(a_stage_hold, vld_q[ST_O-1] && !en[ST_O], vld_q[ST_O-1], "blocked beat lost")
  `EIU_ASSERT_NOW(a_cdf_range, vld_q[ST_C], c_q.cdf <= UNIT_E9, "Phi above one")
  `EIU_ASSERT_NOW(a_sat_excl, vld_q[ST_L0], !(s_q.hi && s_q.lo), "both saturation flags")

endmodule
